/* design/pmpu_pkg.sv */
// pmpu_pkg: shared types and constants of the paged memory protection unit
// payload structs, item kind and status codes, table lookup and write structs
// no dependencies
package pmpu_pkg;

   // page table geometry
   localparam int TABLE_DEPTH = 256;
   localparam int TABLE_AW    = 8;

   // field widths
   localparam int KIND_W   = 3;
   localparam int ADDR_W   = 16;
   localparam int VALUE_W  = 16;
   localparam int FRAME_W  = 8;
   localparam int FLAGS_W  = 16;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 9;
   localparam int MSIZE_W  = 17;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 17;

   // item kinds
   localparam logic [KIND_W-1:0] KIND_READ       = 3'd0;
   localparam logic [KIND_W-1:0] KIND_WRITE      = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SET_FRAME  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_GET_FRAME  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_SET_FLAGS  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_GET_FLAGS  = 3'd5;
   localparam logic [KIND_W-1:0] KIND_TRANSLATE  = 3'd6;
   localparam logic [KIND_W-1:0] KIND_PAGE_COUNT = 3'd7;

   // result status
   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DENIED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FAULT  = 2'd2;

   // flags word bits
   localparam int FLAG_MAPPED_BIT = 0;
   localparam int FLAG_READ_BIT   = 1;
   localparam int FLAG_WRITE_BIT  = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_COUNT  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MEMORY_SIZE = 1'b1;

   localparam logic [COUNT_W-1:0] PAGE_COUNT_RESET  = 9'd256;
   localparam logic [MSIZE_W-1:0] MEMORY_SIZE_RESET = 17'd65536;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic               kernel_mode;
      logic [ADDR_W-1:0]  address;
      logic               two_bytes;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  result_value;
   } rsp_type;

   // table read request, issued when an item is taken
   typedef struct packed {
      logic                en;
      logic [TABLE_AW-1:0] addr_cur;
      logic [TABLE_AW-1:0] addr_next;
   } tbl_rd_type;

   // table write request
   typedef struct packed {
      logic                frame_we;
      logic                flags_we;
      logic [TABLE_AW-1:0] addr;
      logic [VALUE_W-1:0]  value;
   } tbl_wr_type;

   // table read data, unwritten entries already forced to zero
   typedef struct packed {
      logic [FRAME_W-1:0] frame;
      logic [FLAGS_W-1:0] flags;
      logic [FLAGS_W-1:0] flags_next;
   } tbl_lookup_type;

endpackage

/* design/pmpu_ram.sv */
// pmpu_ram: generic single write port, single read port ram with registered read
// no dependencies
module pmpu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] ram_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= ram_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/pmpu_table.sv */
// pmpu_table: frame and flags tables, zeroed by a clearing pass after reset
// depends on pmpu_pkg and pmpu_ram
module pmpu_table (
   input  logic                     clock,
   input  logic                     reset,
   input  pmpu_pkg::tbl_rd_type     rd,
   input  pmpu_pkg::tbl_wr_type     wr,
   output logic                     clearing,
   output pmpu_pkg::tbl_lookup_type lookup
);
   import pmpu_pkg::*;

   logic                clearing_ff, clearing_in;
   logic [TABLE_AW-1:0] clear_addr_ff, clear_addr_in;
   logic                frame_we, flags_we;
   logic [TABLE_AW-1:0] wr_addr;
   logic [VALUE_W-1:0]  wr_value;
   logic [FRAME_W-1:0]  frame_data;
   logic [FLAGS_W-1:0]  flags_data, flags_next_data;

   // one entry of both tables per cycle, the last entry ends the pass
   always_comb begin
      clear_addr_in = clear_addr_ff + TABLE_AW'(1);
      clearing_in   = clearing_ff && (clear_addr_ff != TABLE_AW'(TABLE_DEPTH - 1));
      if (clearing_ff) begin
         frame_we = 1'b1;
         flags_we = 1'b1;
         wr_addr  = clear_addr_ff;
         wr_value = '0;
      end else begin
         frame_we = wr.frame_we;
         flags_we = wr.flags_we;
         wr_addr  = wr.addr;
         wr_value = wr.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff   <= 1'b1;
         clear_addr_ff <= '0;
      end else begin
         clearing_ff   <= clearing_in;
         clear_addr_ff <= clear_addr_in;
      end
   end

   assign clearing = clearing_ff;

   pmpu_ram #(.WIDTH(FRAME_W), .DEPTH(TABLE_DEPTH)) u_frame_ram (
      .clock   (clock),
      .wr_en   (frame_we),
      .wr_addr (wr_addr),
      .wr_data (wr_value[FRAME_W-1:0]),
      .rd_en   (rd.en),
      .rd_addr (rd.addr_cur),
      .rd_data (frame_data)
   );

   // flags kept twice so both pages of a crossing access read in one go
   pmpu_ram #(.WIDTH(FLAGS_W), .DEPTH(TABLE_DEPTH)) u_flags_ram (
      .clock   (clock),
      .wr_en   (flags_we),
      .wr_addr (wr_addr),
      .wr_data (wr_value),
      .rd_en   (rd.en),
      .rd_addr (rd.addr_cur),
      .rd_data (flags_data)
   );

   pmpu_ram #(.WIDTH(FLAGS_W), .DEPTH(TABLE_DEPTH)) u_flags_next_ram (
      .clock   (clock),
      .wr_en   (flags_we),
      .wr_addr (wr_addr),
      .wr_data (wr_value),
      .rd_en   (rd.en),
      .rd_addr (rd.addr_next),
      .rd_data (flags_next_data)
   );

   assign lookup.frame      = frame_data;
   assign lookup.flags      = flags_data;
   assign lookup.flags_next = flags_next_data;

endmodule

/* design/pmpu_eval.sv */
// pmpu_eval: access check, translation and table operation result
// depends on pmpu_pkg
module pmpu_eval #(
   parameter int PAGE_SIZE = 256
) (
   input  pmpu_pkg::req_type                item,
   input  pmpu_pkg::tbl_lookup_type         lookup,
   input  logic [pmpu_pkg::COUNT_W-1:0]     page_count,
   input  logic [pmpu_pkg::MSIZE_W-1:0]     mem_bytes,
   output pmpu_pkg::rsp_type                rsp
);
   import pmpu_pkg::*;

   localparam int                OFFSET_BITS = $clog2(PAGE_SIZE);
   localparam logic [ADDR_W-1:0] OFFSET_MASK = ADDR_W'(PAGE_SIZE - 1);

   logic [ADDR_W-1:0]  vpage, vpage_next, paddr;
   logic               in_table, in_table_next, crossing;
   logic [FLAGS_W-1:0] flags_cur, flags_nxt;
   logic               translate_ok, prot_cur, prot_nxt;
   logic [MSIZE_W-1:0] access_end;

   always_comb begin
      vpage         = item.address >> OFFSET_BITS;
      vpage_next    = (item.address + ADDR_W'(1)) >> OFFSET_BITS;
      in_table      = (vpage[ADDR_W-1:TABLE_AW] == '0);
      in_table_next = (vpage_next[ADDR_W-1:TABLE_AW] == '0);
      crossing      = item.two_bytes && (vpage_next != vpage);
      flags_cur     = in_table      ? lookup.flags      : '0;
      flags_nxt     = in_table_next ? lookup.flags_next : '0;
      translate_ok  = in_table && flags_cur[FLAG_MAPPED_BIT]
                      && ({1'b0, lookup.frame} < page_count);
      paddr         = (ADDR_W'(lookup.frame) << OFFSET_BITS) | (item.address & OFFSET_MASK);
      if (item.kind == KIND_WRITE) begin
         prot_cur = flags_cur[FLAG_WRITE_BIT];
         prot_nxt = flags_nxt[FLAG_WRITE_BIT];
      end else begin
         prot_cur = flags_cur[FLAG_READ_BIT];
         prot_nxt = flags_nxt[FLAG_READ_BIT];
      end
      access_end = {1'b0, item.address} + MSIZE_W'(item.two_bytes) + MSIZE_W'(1);
   end

   always_comb begin
      rsp.status       = STATUS_OK;
      rsp.result_value = '0;
      unique case (item.kind) inside
         KIND_READ, KIND_WRITE: begin
            if (item.two_bytes && (item.address == '1)) begin
               rsp.status = STATUS_DENIED;
            end else if (item.kernel_mode) begin
               if (access_end > mem_bytes) begin
                  rsp.status = STATUS_DENIED;
               end else begin
                  rsp.result_value = item.address;
               end
            end else if (!translate_ok || !prot_cur || (crossing && !prot_nxt)) begin
               rsp.status = STATUS_DENIED;
            end else begin
               rsp.result_value = paddr;
            end
         end
         KIND_SET_FRAME, KIND_GET_FRAME, KIND_SET_FLAGS, KIND_GET_FLAGS: begin
            if (!item.kernel_mode || (item.address[ADDR_W-1:TABLE_AW] != '0)) begin
               rsp.status = STATUS_FAULT;
            end else if (item.kind == KIND_GET_FRAME) begin
               rsp.result_value = VALUE_W'(lookup.frame);
            end else if (item.kind == KIND_GET_FLAGS) begin
               rsp.result_value = lookup.flags;
            end
         end
         KIND_TRANSLATE: begin
            if (!item.kernel_mode) begin
               rsp.status = STATUS_FAULT;
            end else if (!translate_ok) begin
               rsp.status = STATUS_DENIED;
            end else begin
               rsp.result_value = paddr;
            end
         end
         KIND_PAGE_COUNT: begin
            if (!item.kernel_mode) begin
               rsp.status = STATUS_FAULT;
            end else begin
               rsp.result_value = VALUE_W'(page_count);
            end
         end
      endcase
   end

endmodule

/* design/paged_memory_protection_unit.sv */
// paged_memory_protection_unit: top level of the single-level page table unit
// depends on pmpu_pkg, pmpu_table, pmpu_eval (and pmpu_ram below the table)
//
// usage
//  - req channel: one item per handshake (req_valid high, req_stall low); each
//    item is an access check, a table set or get, a translate or a page count
//  - rsp channel: exactly one result item per request item, in order, held
//    stable while rsp_stall is high
//  - csr port: csr_we writes csr_wdata into register csr_index (0 page count,
//    1 memory size) at the clock edge; write only while no item is in flight
//  - result path: a taken item is registered in the read stage alongside the
//    table read data, then its result is registered in the result register
//  - throughput: one item per cycle while neither rsp_stall nor the clearing
//    pass holds req_stall high; the table rams are read once at the edge an item
//    is taken, the decision logic sits between that read and the result register
//  - table writes land at the edge the set item is taken; the next item sees them
//  - reset (synchronous): page count 256, memory size 65536, no item in flight;
//    then a clearing pass zeroes all 256 entries of both tables, one per
//    cycle, with req_stall high until the pass ends
//  - when rsp_stall holds the result, one more item is taken into the read
//    stage; after that req_stall rises until the result leaves
module paged_memory_protection_unit #(
   parameter int PAGE_SIZE = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  pmpu_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output pmpu_pkg::rsp_type                rsp_data,
   input  logic                             csr_we,
   input  logic [pmpu_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pmpu_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import pmpu_pkg::*;

   localparam int OFFSET_BITS = $clog2(PAGE_SIZE);

   // configuration
   logic [COUNT_W-1:0] page_count_ff;
   logic [MSIZE_W-1:0] mem_bytes_ff;

   // read stage: item alongside the table read data
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_item_ff;

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   logic           s2_free, req_accept;
   logic           table_clearing;
   logic [ADDR_W-1:0] req_vpage, req_vpage_next;
   logic           req_table_ok;
   tbl_rd_type     tbl_rd;
   tbl_wr_type     tbl_wr;
   tbl_lookup_type lookup;
   rsp_type        eval_rsp;

   // the result register frees when empty or being taken this cycle
   assign s2_free    = !rsp_valid_ff || !rsp_stall;
   // no item is taken while the tables are being cleared
   assign req_stall  = table_clearing || (s1_valid_ff && !s2_free);
   assign req_accept = req_valid && !req_stall;

   // table addresses of the incoming item
   always_comb begin
      req_vpage      = req_data.address >> OFFSET_BITS;
      req_vpage_next = (req_data.address + ADDR_W'(1)) >> OFFSET_BITS;
      req_table_ok   = req_data.kernel_mode
                       && (req_data.address[ADDR_W-1:TABLE_AW] == '0);

      tbl_rd.en        = req_accept;
      tbl_rd.addr_next = req_vpage_next[TABLE_AW-1:0];
      if ((req_data.kind == KIND_GET_FRAME) || (req_data.kind == KIND_GET_FLAGS)) begin
         tbl_rd.addr_cur = req_data.address[TABLE_AW-1:0];
      end else begin
         tbl_rd.addr_cur = req_vpage[TABLE_AW-1:0];
      end

      // out-of-range index or user mode: nothing written
      tbl_wr.frame_we = req_accept && req_table_ok && (req_data.kind == KIND_SET_FRAME);
      tbl_wr.flags_we = req_accept && req_table_ok && (req_data.kind == KIND_SET_FLAGS);
      tbl_wr.addr     = req_data.address[TABLE_AW-1:0];
      tbl_wr.value    = req_data.value;
   end

   pmpu_table u_table (
      .clock    (clock),
      .reset    (reset),
      .rd       (tbl_rd),
      .wr       (tbl_wr),
      .clearing (table_clearing),
      .lookup   (lookup)
   );

   pmpu_eval #(.PAGE_SIZE(PAGE_SIZE)) u_eval (
      .item       (s1_item_ff),
      .lookup     (lookup),
      .page_count (page_count_ff),
      .mem_bytes  (mem_bytes_ff),
      .rsp        (eval_rsp)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         page_count_ff <= PAGE_COUNT_RESET;
         mem_bytes_ff  <= MEMORY_SIZE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PAGE_COUNT:  page_count_ff <= csr_wdata[COUNT_W-1:0];
            CSR_MEMORY_SIZE: mem_bytes_ff  <= csr_wdata[MSIZE_W-1:0];
         endcase
      end
   end

   // pipeline control
   always_comb begin
      s1_valid_in  = req_accept || (s1_valid_ff && !s2_free);
      rsp_valid_in = s2_free ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_item_ff <= req_data;
      end
      if (s2_free && s1_valid_ff) begin
         rsp_data_ff <= eval_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // a failed item never carries a value
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.status != STATUS_OK) |-> (rsp_data_ff.result_value == '0))
      else $error("failed result carries a non-zero value");

   // a blocked read-stage item stays put
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_free |=> s1_valid_ff && $stable(s1_item_ff))
      else $error("read-stage item lost while result stalled");

   // user-mode table, translate and count items fault
   a_user_fault: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s2_free && !s1_item_ff.kernel_mode
      && (s1_item_ff.kind != KIND_READ) && (s1_item_ff.kind != KIND_WRITE)
      |=> rsp_valid_ff && (rsp_data_ff.status == STATUS_FAULT))
      else $error("user-mode privileged item did not fault");

   // tables are written only by kernel set items
   a_write_priv: assert property (@(posedge clock) disable iff (reset)
      (tbl_wr.frame_we || tbl_wr.flags_we) |-> req_accept && req_data.kernel_mode)
      else $error("table written without a kernel set item");
`endif

endmodule
